// File: hw/rtl/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant violated");

`else

`define ASSERT_PROP(label, clk, rstn, prop)

`define ASSERT_ALWAYS(label, clk, rstn, expr)

`endif

`endif

// File: hw/rtl/svtp_pkg.sv
package svtp_pkg;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_DIGIT,
        CL_MINUS,
        CL_PLUS,
        CL_SPACE,
        CL_DOT,
        CL_NUL,
        CL_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        SC_OTHER,
        SC_P,
        SC_X,
        SC_T,
        SC_E,
        SC_M,
        SC_PCT
    } suffix_code_t;

    typedef struct packed {
        char_class_t  cls;
        logic [3:0]   digit;
        suffix_code_t sfx;
        logic         last;
    } char_item_t;

    localparam int UNIT_BITS = 3;

    localparam logic [UNIT_BITS-1:0] UNIT_PX  = 3'd0;
    localparam logic [UNIT_BITS-1:0] UNIT_PT  = 3'd1;
    localparam logic [UNIT_BITS-1:0] UNIT_EM  = 3'd2;
    localparam logic [UNIT_BITS-1:0] UNIT_MM  = 3'd3;
    localparam logic [UNIT_BITS-1:0] UNIT_PCT = 3'd4;

    localparam logic [2:0] ADDR_DEFAULT_UNIT = 3'h0;

endpackage

// File: hw/rtl/svtp_front.sv
module svtp_front
    import svtp_pkg::*;
#(
    parameter int CHAR_BITS = 16
) (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_BITS-1:0] char_code,
    input  logic                 has_char,
    input  logic                 last,
    output logic                 q_valid,
    input  logic                 q_ready,
    output char_item_t           q_item
);

    logic is_digit;
    logic is_space;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb begin
        is_digit = (char_code >= CHAR_BITS'(8'h30)) && (char_code <= CHAR_BITS'(8'h39));
        is_space = (char_code == CHAR_BITS'(8'h20)) ||
                   ((char_code >= CHAR_BITS'(8'h09)) && (char_code <= CHAR_BITS'(8'h0D)));

        q_item.last  = last;
        q_item.digit = char_code[3:0];

        priority if (!has_char) begin
            q_item.cls = CL_NONE;
        end else if (char_code == '0) begin
            q_item.cls = CL_NUL;
        end else if (is_digit) begin
            q_item.cls = CL_DIGIT;
        end else if (char_code == CHAR_BITS'(8'h2D)) begin
            q_item.cls = CL_MINUS;
        end else if (char_code == CHAR_BITS'(8'h2B)) begin
            q_item.cls = CL_PLUS;
        end else if (char_code == CHAR_BITS'(8'h2E)) begin
            q_item.cls = CL_DOT;
        end else if (is_space) begin
            q_item.cls = CL_SPACE;
        end else begin
            q_item.cls = CL_OTHER;
        end

        priority if (char_code == CHAR_BITS'(8'h70)) begin
            q_item.sfx = SC_P;
        end else if (char_code == CHAR_BITS'(8'h78)) begin
            q_item.sfx = SC_X;
        end else if (char_code == CHAR_BITS'(8'h74)) begin
            q_item.sfx = SC_T;
        end else if (char_code == CHAR_BITS'(8'h65)) begin
            q_item.sfx = SC_E;
        end else if (char_code == CHAR_BITS'(8'h6D)) begin
            q_item.sfx = SC_M;
        end else if (char_code == CHAR_BITS'(8'h25)) begin
            q_item.sfx = SC_PCT;
        end else begin
            q_item.sfx = SC_OTHER;
        end
    end

endmodule

// File: hw/rtl/svtp_fifo.sv
module svtp_fifo
    import svtp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  char_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output char_item_t out_item
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    char_item_t            store_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  push, pop;

    assign in_ready  = count_reg != CNT_BITS'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: hw/rtl/svtp_back.sv
`include "assert_macros.svh"

module svtp_back
    import svtp_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  char_item_t           item,
    input  logic [UNIT_BITS-1:0] default_unit,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 res_ok,
    output logic [63:0]          res_value,
    output logic [UNIT_BITS-1:0] res_unit
);

    localparam logic [VALUE_BITS-1:0] MAG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] INT_LIMIT = MAG_LIMIT / 100;

    typedef enum logic [2:0] {
        PH_START,
        PH_WS,
        PH_SIGNED,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_SUFFIX,
        PH_DONE
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] int_reg, int_next;
    logic [6:0]            frac_reg, frac_next;
    logic [4:0]            fdig_reg, fdig_next;
    suffix_code_t          sfx_reg [3];
    suffix_code_t          sfx_next [3];
    logic [1:0]            scnt_reg, scnt_next;
    logic                  err_reg, err_next;

    // finish stage
    logic                  f_valid_reg;
    logic                  f_ok_reg;
    logic                  f_neg_reg;
    logic [VALUE_BITS-1:0] f_int_reg;
    logic [6:0]            f_frac_reg;
    logic [UNIT_BITS-1:0]  f_unit_reg;

    // magnitude stage
    logic                  g_valid_reg;
    logic                  g_ok_reg;
    logic                  g_neg_reg;
    logic [VALUE_BITS-1:0] g_mag_reg;
    logic [UNIT_BITS-1:0]  g_unit_reg;

    // output register
    logic                  o_valid_reg;
    logic                  o_ok_reg;
    logic [63:0]           o_value_reg;
    logic [UNIT_BITS-1:0]  o_unit_reg;

    logic                  adv, pop, take, end_item;
    logic                  do_int, do_frac, do_sfx, do_fail;
    logic [VALUE_BITS-1:0] int_calc;
    logic [4:0]            fdig_inc;
    logic                  ok_pre;
    logic [UNIT_BITS-1:0]  unit_pick;
    logic [VALUE_BITS-1:0] mag_calc;
    logic                  lim_ok;
    logic [63:0]           mag_wide;

    assign adv        = !(o_valid_reg && !res_ready);
    assign item_ready = !item.last || adv;
    assign pop        = item_valid && item_ready;
    assign take       = pop && (item.cls != CL_NONE);
    assign end_item   = pop && item.last;

    assign int_calc = (int_reg << 3) + (int_reg << 1) + VALUE_BITS'(item.digit);
    assign fdig_inc = fdig_reg + 5'd1;

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        sfx_next   = sfx_reg;
        scnt_next  = scnt_reg;
        err_next   = err_reg;
        do_int     = 1'b0;
        do_frac    = 1'b0;
        do_sfx     = 1'b0;
        do_fail    = 1'b0;

        if (take && phase_reg != PH_DONE) begin
            if (item.cls == CL_NUL) begin
                if (phase_reg != PH_INT && phase_reg != PH_FRAC && phase_reg != PH_SUFFIX) begin
                    err_next = 1'b1;
                end
                phase_next = PH_DONE;
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        unique case (item.cls)
                            CL_MINUS: begin
                                if (!neg_reg) begin
                                    neg_next = 1'b1;
                                end else begin
                                    neg_next   = 1'b0;
                                    phase_next = PH_SIGNED;
                                end
                            end
                            CL_PLUS:  phase_next = PH_SIGNED;
                            CL_SPACE: phase_next = PH_WS;
                            CL_DIGIT: do_int = 1'b1;
                            CL_DOT:   phase_next = PH_DOT;
                            default:  do_fail = 1'b1;
                        endcase
                    end
                    PH_WS: begin
                        unique case (item.cls)
                            CL_SPACE: phase_next = PH_WS;
                            CL_PLUS:  phase_next = PH_SIGNED;
                            CL_MINUS: begin
                                neg_next   = !neg_reg;
                                phase_next = PH_SIGNED;
                            end
                            CL_DIGIT: do_int = 1'b1;
                            default:  do_fail = 1'b1;
                        endcase
                    end
                    PH_SIGNED: begin
                        if (item.cls == CL_DIGIT) begin
                            do_int = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_INT: begin
                        priority if (item.cls == CL_DIGIT) begin
                            do_int = 1'b1;
                        end else if (item.cls == CL_DOT) begin
                            phase_next = PH_DOT;
                        end else begin
                            do_sfx = 1'b1;
                        end
                    end
                    PH_DOT: begin
                        if (item.cls == CL_DIGIT) begin
                            do_frac = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_FRAC: begin
                        if (item.cls == CL_DIGIT) begin
                            do_frac = 1'b1;
                        end else begin
                            do_sfx = 1'b1;
                        end
                    end
                    PH_SUFFIX: do_sfx = 1'b1;
                    PH_DONE:   phase_next = PH_DONE;
                endcase
            end
        end

        if (do_int) begin
            int_next   = int_calc;
            phase_next = PH_INT;
            if (int_calc > INT_LIMIT) begin
                do_fail = 1'b1;
            end
        end
        if (do_frac) begin
            fdig_next  = fdig_inc;
            phase_next = PH_FRAC;
            priority if (fdig_inc > 5'd19) begin
                do_fail = 1'b1;
            end else if (fdig_inc == 5'd1) begin
                frac_next = {item.digit, 3'b000} + {2'b00, item.digit, 1'b0};
            end else if (fdig_inc == 5'd2) begin
                frac_next = frac_reg + {3'b000, item.digit};
            end else begin
                frac_next = frac_reg;
            end
        end
        if (do_sfx) begin
            if (scnt_reg != 2'd3) begin
                sfx_next[scnt_reg] = item.sfx;
                scnt_next          = scnt_reg + 2'd1;
            end
            phase_next = PH_SUFFIX;
        end
        if (do_fail) begin
            err_next   = 1'b1;
            phase_next = PH_DONE;
        end

        ok_pre = !err_next && (phase_next == PH_INT || phase_next == PH_FRAC ||
                               phase_next == PH_SUFFIX || phase_next == PH_DONE);

        priority if (scnt_next == 2'd2 && sfx_next[0] == SC_P && sfx_next[1] == SC_X) begin
            unit_pick = UNIT_PX;
        end else if (scnt_next == 2'd2 && sfx_next[0] == SC_P && sfx_next[1] == SC_T) begin
            unit_pick = UNIT_PT;
        end else if (scnt_next == 2'd2 && sfx_next[0] == SC_E && sfx_next[1] == SC_M) begin
            unit_pick = UNIT_EM;
        end else if (scnt_next == 2'd2 && sfx_next[0] == SC_M && sfx_next[1] == SC_M) begin
            unit_pick = UNIT_MM;
        end else if (scnt_next == 2'd1 && sfx_next[0] == SC_PCT) begin
            unit_pick = UNIT_PCT;
        end else if (default_unit <= UNIT_PCT) begin
            unit_pick = default_unit;
        end else begin
            unit_pick = UNIT_PX;
        end
    end

    // times one hundred as shifted adds
    assign mag_calc = (f_int_reg << 6) + (f_int_reg << 5) + (f_int_reg << 2) +
                      VALUE_BITS'(f_frac_reg);

    assign lim_ok   = g_neg_reg ? (g_mag_reg <= MAG_LIMIT) : (g_mag_reg < MAG_LIMIT);
    assign mag_wide = 64'(g_mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            neg_reg     <= 1'b0;
            int_reg     <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            sfx_reg     <= '{SC_OTHER, SC_OTHER, SC_OTHER};
            scnt_reg    <= '0;
            err_reg     <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (end_item) begin
                phase_reg <= PH_START;
                neg_reg   <= 1'b0;
                int_reg   <= '0;
                frac_reg  <= '0;
                fdig_reg  <= '0;
                sfx_reg   <= '{SC_OTHER, SC_OTHER, SC_OTHER};
                scnt_reg  <= '0;
                err_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                int_reg   <= int_next;
                frac_reg  <= frac_next;
                fdig_reg  <= fdig_next;
                sfx_reg   <= sfx_next;
                scnt_reg  <= scnt_next;
                err_reg   <= err_next;
            end

            if (adv) begin
                f_valid_reg <= end_item;
                f_ok_reg    <= ok_pre;
                f_neg_reg   <= neg_next;
                f_int_reg   <= int_next;
                f_frac_reg  <= frac_next;
                f_unit_reg  <= unit_pick;

                g_valid_reg <= f_valid_reg;
                g_ok_reg    <= f_ok_reg;
                g_neg_reg   <= f_neg_reg;
                g_mag_reg   <= mag_calc;
                g_unit_reg  <= f_unit_reg;

                o_valid_reg <= g_valid_reg;
                o_ok_reg    <= g_ok_reg && lim_ok;
                if (g_ok_reg && lim_ok) begin
                    o_value_reg <= g_neg_reg ? (64'd0 - mag_wide) : mag_wide;
                    o_unit_reg  <= g_unit_reg;
                end else begin
                    o_value_reg <= '0;
                    o_unit_reg  <= UNIT_PX;
                end
            end
        end
    end

    assign res_valid = o_valid_reg;
    assign res_ok    = o_ok_reg;
    assign res_value = o_value_reg;
    assign res_unit  = o_unit_reg;

    `ASSERT_PROP(a_err_means_done, aclk, aresetn, err_reg |-> phase_reg == PH_DONE)
    `ASSERT_PROP(a_int_in_range, aclk, aresetn, !err_reg |-> int_reg <= INT_LIMIT)
    `ASSERT_ALWAYS(a_frac_range, aclk, aresetn, frac_reg <= 7'd99 && fdig_reg <= 5'd20)
    `ASSERT_PROP(a_invalid_is_zero, aclk, aresetn,
                 o_valid_reg && !o_ok_reg |-> o_value_reg == '0 && o_unit_reg == UNIT_PX)
    `ASSERT_PROP(a_last_held_on_stall, aclk, aresetn,
                 item_valid && item.last && !adv |-> !item_ready)

endmodule

// File: hw/rtl/size_value_text_parser.sv
// a string's result passes the finish, magnitude and output registers to m_tvalid
// one character per cycle when not stalled; one result per string, one per cycle at most
// the parse register takes each character as it leaves the queue, the value times 100 and
// its range check take one pipeline stage each after the string ends
// reset: synchronous active-low aresetn clears the parse state, queue, pipeline and
// default_unit; the block accepts transactions in the first cycle after reset
module size_value_text_parser
    import svtp_pkg::*;
#(
    parameter int CHAR_BITS   = 16,
    parameter int VALUE_BITS  = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((CHAR_BITS + 7) / 8) * 8-1:0] s_tdata,   // char_code
    input  logic [0:0]                           s_tuser,   // has_char
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [71:0]                          m_tdata,   // value_hundredths, unit
    output logic [0:0]                           m_tuser,   // valid_res
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [UNIT_BITS-1:0] default_unit_reg, default_unit_next;
    logic                 cfg_hit;

    logic                 q_in_valid, q_in_ready;
    char_item_t           q_in_item;
    logic                 q_out_valid, q_out_ready;
    char_item_t           q_out_item;

    logic                 res_ok;
    logic [63:0]          res_value;
    logic [UNIT_BITS-1:0] res_unit;

    assign pready  = 1'b1;
    assign cfg_hit = paddr[2] == ADDR_DEFAULT_UNIT[2];
    assign prdata  = cfg_hit ? {{(32 - UNIT_BITS){1'b0}}, default_unit_reg} : '0;

    always_comb begin
        default_unit_next = default_unit_reg;
        if (psel && penable && pwrite && pready && cfg_hit) begin
            default_unit_next = pwdata[UNIT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_unit_reg <= UNIT_PX;
        end else begin
            default_unit_reg <= default_unit_next;
        end
    end

    svtp_front #(
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata[CHAR_BITS-1:0]),
        .has_char  (s_tuser[0]),
        .last      (s_tlast),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_item    (q_in_item)
    );

    svtp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    svtp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (q_out_valid),
        .item_ready   (q_out_ready),
        .item         (q_out_item),
        .default_unit (default_unit_reg),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_ok       (res_ok),
        .res_value    (res_value),
        .res_unit     (res_unit)
    );

    assign m_tdata = {5'b0, res_unit, res_value};
    assign m_tuser = res_ok;

endmodule

// File: test/tb_size_value_text_parser.sv
module tb_size_value_text_parser
    import svtp_pkg::*;
();

    typedef enum logic [2:0] {
        ST_START,
        ST_BLANK,
        ST_SIGNED,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_SUFFIX,
        ST_DONE
    } scan_state_t;

    typedef struct {
        bit          ok;
        logic [63:0] hundredths;
        logic [2:0]  unit;
    } size_result_t;

    localparam logic [15:0] CH_NUL   = 16'h0000;
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_PCT   = 16'h0025;
    localparam logic [15:0] CH_PLUS  = 16'h002B;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_DOT   = 16'h002E;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_NINE  = 16'h0039;
    localparam logic [15:0] CH_E     = 16'h0065;
    localparam logic [15:0] CH_M     = 16'h006D;
    localparam logic [15:0] CH_P     = 16'h0070;
    localparam logic [15:0] CH_T     = 16'h0074;
    localparam logic [15:0] CH_X     = 16'h0078;

    localparam logic [63:0] MAG_LIMIT    = 64'h8000_0000_0000_0000;
    localparam int          RANDOM_ITEMS = 930;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // char_code
    logic [0:0]  s_tuser;   // has_char
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // value_hundredths, unit
    logic [0:0]  m_tuser;   // valid_res
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    size_value_text_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // parser state as the block should hold it
    scan_state_t scan_st;
    bit          neg_flag;
    logic [63:0] int_acc;
    int          frac_acc;
    int          frac_cnt;
    logic [15:0] sfx_txt [3];
    int          sfx_cnt;
    bit          bad;
    logic [2:0]  dflt_unit;

    size_result_t size_q[$];
    logic [15:0]  line_q[$];

    int n_items;
    int n_results;
    int n_valid;
    int n_errors;
    int n_units [5];
    int rx_stall;
    int rx_hold;
    bit quiet;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit is_blank(input logic [15:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_num(input logic [15:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_scan();
        scan_st  = ST_START;
        neg_flag = 1'b0;
        int_acc  = '0;
        frac_acc = 0;
        frac_cnt = 0;
        sfx_txt  = '{default: '0};
        sfx_cnt  = 0;
        bad      = 1'b0;
    endfunction

    function automatic void abort_scan();
        bad     = 1'b1;
        scan_st = ST_DONE;
    endfunction

    function automatic void int_digit(input logic [15:0] c);
        int_acc = int_acc * 64'd10 + 64'(c - CH_ZERO);
        scan_st = ST_INT;
        if (int_acc > MAG_LIMIT / 64'd100)
            abort_scan();
    endfunction

    function automatic void frac_digit(input logic [15:0] c);
        int d;
        d = int'(c - CH_ZERO);
        frac_cnt++;
        scan_st = ST_FRAC;
        if (frac_cnt > 19)
            abort_scan();
        else if (frac_cnt == 1)
            frac_acc = d * 10;
        else if (frac_cnt == 2)
            frac_acc += d;
    endfunction

    function automatic void suffix_char(input logic [15:0] c);
        if (sfx_cnt < 3) begin
            sfx_txt[sfx_cnt] = c;
            sfx_cnt++;
        end
        scan_st = ST_SUFFIX;
    endfunction

    function automatic void scan_char(input logic [15:0] c);
        if (scan_st == ST_DONE)
            return;
        if (c == CH_NUL) begin
            if (scan_st != ST_INT && scan_st != ST_FRAC && scan_st != ST_SUFFIX)
                bad = 1'b1;
            scan_st = ST_DONE;
            return;
        end
        case (scan_st)
            ST_START: begin
                if (c == CH_MINUS) begin
                    if (!neg_flag) begin
                        neg_flag = 1'b1;
                    end else begin
                        neg_flag = 1'b0;
                        scan_st  = ST_SIGNED;
                    end
                end else if (c == CH_PLUS) scan_st = ST_SIGNED;
                else if (is_blank(c)) scan_st = ST_BLANK;
                else if (is_num(c)) int_digit(c);
                else if (c == CH_DOT) scan_st = ST_DOT;
                else abort_scan();
            end
            ST_BLANK: begin
                if (!is_blank(c)) begin
                    if (c == CH_PLUS) begin
                        scan_st = ST_SIGNED;
                    end else if (c == CH_MINUS) begin
                        neg_flag = ~neg_flag;
                        scan_st  = ST_SIGNED;
                    end else if (is_num(c)) int_digit(c);
                    else abort_scan();
                end
            end
            ST_SIGNED: begin
                if (is_num(c)) int_digit(c);
                else abort_scan();
            end
            ST_INT: begin
                if (is_num(c)) int_digit(c);
                else if (c == CH_DOT) scan_st = ST_DOT;
                else suffix_char(c);
            end
            ST_DOT: begin
                if (is_num(c)) frac_digit(c);
                else abort_scan();
            end
            ST_FRAC: begin
                if (is_num(c)) frac_digit(c);
                else suffix_char(c);
            end
            default: begin
                suffix_char(c);
            end
        endcase
    endfunction

    function automatic logic [2:0] match_unit();
        if (sfx_cnt == 2 && sfx_txt[0] == CH_P && sfx_txt[1] == CH_X) return UNIT_PX;
        if (sfx_cnt == 2 && sfx_txt[0] == CH_P && sfx_txt[1] == CH_T) return UNIT_PT;
        if (sfx_cnt == 2 && sfx_txt[0] == CH_E && sfx_txt[1] == CH_M) return UNIT_EM;
        if (sfx_cnt == 2 && sfx_txt[0] == CH_M && sfx_txt[1] == CH_M) return UNIT_MM;
        if (sfx_cnt == 1 && sfx_txt[0] == CH_PCT) return UNIT_PCT;
        return (dflt_unit <= UNIT_PCT) ? dflt_unit : UNIT_PX;
    endfunction

    function automatic size_result_t close_scan();
        size_result_t r;
        logic [63:0]  mag;
        r.ok = !bad && (scan_st == ST_INT || scan_st == ST_FRAC ||
                        scan_st == ST_SUFFIX || scan_st == ST_DONE);
        mag = '0;
        if (r.ok) begin
            mag = int_acc * 64'd100 + 64'(frac_acc);
            if (neg_flag ? (mag > MAG_LIMIT) : (mag > MAG_LIMIT - 64'd1))
                r.ok = 1'b0;
        end
        if (r.ok) begin
            r.hundredths = neg_flag ? (64'd0 - mag) : mag;
            r.unit       = match_unit();
        end else begin
            r.hundredths = '0;
            r.unit       = UNIT_PX;
        end
        clear_scan();
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        size_result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                rx_stall = quiet ? 0 : $urandom_range(0, 4);
                if (size_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    n_errors++;
                end else begin
                    e = size_q.pop_front();
                    if (m_tuser[0] !== e.ok) begin
                        $error("valid_res expected %0d got %0d", e.ok, m_tuser[0]);
                        n_errors++;
                    end
                    if (m_tdata[63:0] !== e.hundredths) begin
                        $error("value_hundredths expected %0d got %0d",
                               $signed(e.hundredths), $signed(m_tdata[63:0]));
                        n_errors++;
                    end
                    if (m_tdata[66:64] !== e.unit) begin
                        $error("unit expected %0d got %0d", e.unit, m_tdata[66:64]);
                        n_errors++;
                    end
                    if (e.ok) begin
                        n_valid++;
                        n_units[e.unit]++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] || s_tlast)
                    n_items++;
                if (s_tuser[0])
                    scan_char(s_tdata);
                if (s_tlast)
                    size_q.push_back(close_scan());
            end
        end
    end

    // receiver: per-result stall plus an occasional long hold
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [15:0] code, input bit has, input bit lst);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= has;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop offering and wait for every expected result plus pipeline slack
    task automatic settle();
        s_tvalid <= 1'b0;
        while (size_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_default_unit(input logic [2:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEFAULT_UNIT;
        pwdata  <= {29'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[2:0] !== val) begin
            $error("default_unit readback expected %0d got %0d", val, prdata[2:0]);
            n_errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        dflt_unit = val;
    endtask

    task automatic add_text(input string txt);
        foreach (txt[i])
            line_q.push_back(16'(txt[i]));
    endtask

    task automatic add_digits(input int n);
        repeat (n) line_q.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
    endtask

    // send the queued text; an empty tail ends it with a no-character item
    task automatic emit_line(input bit empty_tail);
        int n;
        n = line_q.size();
        if (n == 0)
            empty_tail = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(16'($urandom), 1'b0, 1'b0);
            send_item(line_q[i], 1'b1, !empty_tail && i == n - 1);
        end
        if (empty_tail)
            send_item(16'($urandom), 1'b0, 1'b1);
        line_q.delete();
    endtask

    task automatic text_line(input string txt);
        add_text(txt);
        emit_line(1'b0);
    endtask

    task automatic test_directed();
        send_item(16'hFFFF, 1'b0, 1'b1);
        text_line("-12.5px");
        text_line(".5");
        text_line("-.5em");
        text_line("--3pt");
        text_line("- -5");
        text_line(" \t-7mm");
        text_line("+.5");
        text_line("abc");
        text_line("5.");
        text_line(".");
        text_line("3.14159%");
        text_line("1.2xyz");
        text_line("1pxx");
        text_line("12-3");
        add_text("7");
        line_q.push_back(CH_NUL);
        line_q.push_back(16'hFFFF);
        line_q.push_back(16'h8000);
        emit_line(1'b0);
        line_q.push_back(CH_NUL);
        emit_line(1'b0);
        text_line("92233720368547758.07");
        text_line("92233720368547758.08");
        text_line("-92233720368547758.08");
        text_line("-92233720368547758.09");
        text_line("922337203685477580");
        text_line("0.1234567890123456789pt");
        text_line("0.12345678901234567890pt");
        add_text("42mm");
        emit_line(1'b1);
        settle();
    endtask

    task automatic test_default_unit();
        logic [2:0] order [8] = '{3'd7, 3'd4, 3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd2};
        foreach (order[i]) begin
            write_default_unit(order[i]);
            text_line("9q");
            text_line("4");
            text_line("6.25%");
            text_line("1em");
            settle();
        end
    endtask

    task automatic test_backpressure();
        quiet   = 1'b1;
        rx_hold = 80;
        repeat (24) begin
            add_digits($urandom_range(1, 2));
            emit_line(1'b0);
        end
        settle();
        quiet = 1'b0;
        repeat (10) begin
            text_line("8px");
            settle();
        end
    endtask

    task automatic make_size_line();
        int pick;
        int n;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2))
                line_q.push_back($urandom_range(0, 5) == 0 ? CH_SPACE
                                 : CH_TAB + 16'($urandom_range(0, 4)));
        pick = $urandom_range(0, 19);
        if (pick < 4) add_text("-");
        else if (pick < 6) add_text("+");
        else if (pick == 6) add_text("--");
        else if (pick == 7) add_text("- -");
        if ($urandom_range(0, 19) == 0) begin
            add_text("92233720368547758");
            if ($urandom_range(0, 3) != 0) begin
                add_text(".0");
                add_digits(1);
            end
        end else begin
            if ($urandom_range(0, 11) == 0) n = $urandom_range(15, 19);
            else if ($urandom_range(0, 11) == 0) n = 0;
            else n = $urandom_range(1, 5);
            add_digits(n);
            if ($urandom_range(0, 1) == 1) begin
                add_text(".");
                add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(18, 21)
                                                       : $urandom_range(0, 3));
            end
        end
        case ($urandom_range(0, 9))
            0: add_text("px");
            1: add_text("pt");
            2: add_text("em");
            3: add_text("mm");
            4: add_text("%");
            5: ;
            6: add_text("pxx");
            7: repeat ($urandom_range(1, 3))
                   line_q.push_back(16'h61 + 16'($urandom_range(0, 25)));
            8: line_q.push_back(16'($urandom));
            default: add_text("px");
        endcase
        if ($urandom_range(0, 19) == 0) begin
            line_q.push_back(CH_NUL);
            repeat ($urandom_range(0, 2)) line_q.push_back(16'($urandom));
        end
    endtask

    function automatic logic [15:0] pool_char();
        case ($urandom_range(0, 7))
            0: return CH_MINUS;
            1: return CH_PLUS;
            2: return CH_DOT;
            3: return CH_SPACE;
            4: return CH_ZERO + 16'($urandom_range(0, 9));
            5: return CH_P;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_text();
        int goal;
        int lines;
        int pick;
        goal  = n_items + RANDOM_ITEMS;
        lines = 0;
        while (n_items < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 6)) line_q.push_back(pool_char());
            end else if (pick < 22) begin
                make_size_line();
                if (line_q.size() != 0)
                    line_q[$urandom_range(0, line_q.size() - 1)] = pool_char();
            end else begin
                make_size_line();
            end
            emit_line($urandom_range(0, 4) == 0);
            lines++;
            if (lines % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (lines % 150 == 0) begin
                settle();
                write_default_unit(3'($urandom_range(0, 7)));
            end
        end
        settle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        n_items   = 0;
        n_results = 0;
        n_valid   = 0;
        n_errors  = 0;
        n_units   = '{default: 0};
        rx_stall  = 0;
        rx_hold   = 0;
        quiet     = 1'b0;
        dflt_unit = UNIT_PX;
        clear_scan();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_default_unit();
        test_backpressure();
        test_random_text();

        $display("%0d character transactions, %0d results (%0d valid, %0d rejected)",
                 n_items, n_results, n_valid, n_results - n_valid);
        $display("units px/pt/em/mm/pct: %0d/%0d/%0d/%0d/%0d, all default_unit codes, long hold",
                 n_units[0], n_units[1], n_units[2], n_units[3], n_units[4]);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
